@@ hdl/wssa_pkg.sv @@
`default_nettype none
package wssa_pkg;
  localparam int NumSharesDefault  = 8;
  localparam int CountWidthDefault = 16;
  localparam int PrioWidth         = 16;
  localparam int FieldWidth        = 16;
  localparam int ShareWidth        = 3;
  localparam int NumPrioRegs       = 8;
  localparam int CfgIndexWidth     = 3;
  localparam logic [PrioWidth-1:0] PrioReset = PrioWidth'(50);

  typedef enum logic [2:0] {
    ACT_ENQUEUE   = 3'd0,
    ACT_DEQUEUE   = 3'd1,
    ACT_CONSUME   = 3'd2,
    ACT_QUERY     = 3'd3,
    ACT_RECALC    = 3'd4
  } action_t;
endpackage
`default_nettype wire

@@ hdl/wssa_in_if.sv @@
`default_nettype none
interface wssa_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  share;
  logic [15:0] total_slots;
  modport source (output valid, action, share, total_slots, input ready);
  modport sink   (input valid, action, share, total_slots, output ready);
endinterface
`default_nettype wire

@@ hdl/wssa_out_if.sv @@
`default_nettype none
interface wssa_out_if;
  logic        valid;
  logic        ready;
  logic        start_allowed;
  logic [15:0] share_slots;
  logic [15:0] share_queued;
  modport source (output valid, start_allowed, share_slots, share_queued, input ready);
  modport sink   (input valid, start_allowed, share_slots, share_queued, output ready);
endinterface
`default_nettype wire

@@ hdl/weighted_share_slot_allocator_core.sv @@
`default_nettype none
// Enqueue, dequeue, consume and query: the result word is registered on accept.
// Recalculate: summing over all NUM_SHARES, then for each active share a multiply,
// a 32-step restoring divide and an apply, with idle shares skipped, then a
// round-robin fill (up to NUM_SHARES shares visited per leftover slot) and the
// result word. One word at a time; the next word is taken no earlier than the
// cycle in which the previous result word is accepted.
// Synchronous reset: priorities to 50, all queued and slot counts to zero.
module weighted_share_slot_allocator_core
  import wssa_pkg::*;
#(
  parameter int NUM_SHARES  = NumSharesDefault,
  parameter int COUNT_WIDTH = CountWidthDefault
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_we,
  input  wire [CfgIndexWidth-1:0] cfg_index,
  input  wire [PrioWidth-1:0]     cfg_data,
  wssa_in_if.sink                 req,
  wssa_out_if.source              rsp
);
  localparam int IdxW  = (NUM_SHARES > 1) ? $clog2(NUM_SHARES) : 1;
  localparam int PsW   = PrioWidth + 3;
  localparam int QsW   = COUNT_WIDTH + 3;
  localparam int UsedW = ((COUNT_WIDTH > FieldWidth) ? COUNT_WIDTH : FieldWidth) + 3;
  localparam int ProdW = PrioWidth + FieldWidth;
  localparam int BitW  = $clog2(ProdW);
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SHARES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_MUL, S_DIV, S_APPLY, S_FILL, S_RESP
  } state_t;

  state_t                 state;
  logic [PrioWidth-1:0]   prio   [NUM_SHARES];
  logic [COUNT_WIDTH-1:0] queued [NUM_SHARES];
  logic [COUNT_WIDTH-1:0] slots  [NUM_SHARES];
  logic [IdxW-1:0]        k;
  logic [IdxW-1:0]        sidx;
  logic [PsW-1:0]         prio_sum;
  logic [QsW-1:0]         queued_sum;
  logic [UsedW-1:0]       used;
  logic [FieldWidth-1:0]  total;
  logic [ProdW-1:0]       dividend;
  logic [PsW-1:0]         rem;
  logic [ProdW-1:0]       quot;
  logic [BitW-1:0]        bitcnt;

  logic                   share_ok;
  logic [IdxW-1:0]        addr;
  logic [COUNT_WIDTH-1:0] cur_q;
  logic [COUNT_WIDTH-1:0] cur_s;
  logic [COUNT_WIDTH-1:0] q_new;
  logic [COUNT_WIDTH-1:0] s_new;
  logic                   rsp_load;
  logic [PsW:0]           rem_sh;
  logic                   rem_ge;
  logic [ProdW-1:0]       qv;
  logic [ProdW-1:0]       q_ext;
  logic [COUNT_WIDTH-1:0] q_final;
  logic                   fill_more;
  logic [31:0]            q_wide;
  logic [31:0]            s_wide;

  assign share_ok = {1'b0, req.share} < 4'(NUM_SHARES);
  assign req.ready = (state == S_IDLE) && (!rsp.valid || rsp.ready);

  // Pick the single access index: requested share, saved share or sweep index
  always_comb begin
    unique case (state)
      S_IDLE:  addr = req.share[IdxW-1:0];
      S_RESP:  addr = sidx;
      default: addr = k;
    endcase
  end
  assign cur_q = queued[addr];
  assign cur_s = slots[addr];

  // Saturating update of the addressed counts for enqueue, dequeue and consume
  always_comb begin
    q_new = cur_q;
    s_new = cur_s;
    if (state == S_IDLE) begin
      unique case (req.action)
        ACT_ENQUEUE: if (cur_q != CountMax) q_new = cur_q + 1'b1;
        ACT_DEQUEUE: if (cur_q != '0) q_new = cur_q - 1'b1;
        ACT_CONSUME: if (cur_s != '0) s_new = cur_s - 1'b1;
        default: ;
      endcase
    end
  end

  // A new result word is loaded this cycle
  assign rsp_load = ((state == S_IDLE) && req.valid && req.ready &&
                     !(share_ok && (req.action == ACT_RECALC))) || (state == S_RESP);

  // Divide step and quotient clamp
  assign rem_sh  = {rem, dividend[ProdW-1]};
  assign rem_ge  = rem_sh >= {1'b0, prio_sum};
  assign qv      = (prio_sum == '0) ? '0 : quot;
  assign q_ext   = ProdW'(cur_q);
  always_comb begin
    priority if (qv > q_ext) q_final = cur_q;
    else if (qv == '0)       q_final = COUNT_WIDTH'(1);
    else                     q_final = qv[COUNT_WIDTH-1:0];
  end
  assign fill_more = (used < UsedW'(queued_sum)) && (used < UsedW'(total));

  // Hold state, counters and the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      for (int i = 0; i < NUM_SHARES; i++) begin
        prio[i]   <= PrioReset;
        queued[i] <= '0;
        slots[i]  <= '0;
      end
    end else begin
      if (rsp.valid && rsp.ready && !rsp_load) rsp.valid <= 1'b0;
      if (cfg_we && ({1'b0, cfg_index} < (CfgIndexWidth+1)'(NUM_SHARES)))
        prio[cfg_index[IdxW-1:0]] <= cfg_data;

      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            if (!share_ok) begin
              rsp.valid         <= 1'b1;
              rsp.start_allowed <= 1'b0;
              rsp.share_slots   <= '0;
              rsp.share_queued  <= '0;
            end else if (req.action == ACT_RECALC) begin
              sidx       <= addr;
              total      <= req.total_slots;
              k          <= '0;
              prio_sum   <= '0;
              queued_sum <= '0;
              used       <= '0;
              state      <= S_SUM;
            end else begin
              rsp.valid         <= 1'b1;
              rsp.start_allowed <= (s_new != '0);
              rsp.share_slots   <= s_wide[FieldWidth-1:0];
              rsp.share_queued  <= q_wide[FieldWidth-1:0];
              queued[addr]      <= q_new;
              slots[addr]       <= s_new;
            end
          end
        end
        // Clear slots and sum priorities and queues of active shares
        S_SUM: begin
          slots[k] <= '0;
          if (cur_q != '0) begin
            prio_sum   <= prio_sum + PsW'(prio[k]);
            queued_sum <= queued_sum + QsW'(cur_q);
          end
          if (k == LastIdx) begin
            k     <= '0;
            state <= S_MUL;
          end else begin
            k <= k + 1'b1;
          end
        end
        // Skip idle shares; form priority times total for the divider
        S_MUL: begin
          if (cur_q == '0) begin
            if (k == LastIdx) begin
              k     <= '0;
              state <= S_FILL;
            end else begin
              k <= k + 1'b1;
            end
          end else begin
            dividend <= prio[k] * total;
            rem      <= '0;
            quot     <= '0;
            bitcnt   <= '0;
            state    <= S_DIV;
          end
        end
        // One quotient bit per cycle
        S_DIV: begin
          dividend <= {dividend[ProdW-2:0], 1'b0};
          rem      <= rem_ge ? PsW'(rem_sh - {1'b0, prio_sum}) : rem_sh[PsW-1:0];
          quot     <= {quot[ProdW-2:0], rem_ge};
          bitcnt   <= bitcnt + 1'b1;
          if (bitcnt == BitW'(ProdW - 1)) state <= S_APPLY;
        end
        // Cap at the queue, raise to one, book the slots
        S_APPLY: begin
          slots[k] <= q_final;
          used     <= used + UsedW'(q_final);
          if (k == LastIdx) begin
            k     <= '0;
            state <= S_FILL;
          end else begin
            k     <= k + 1'b1;
            state <= S_MUL;
          end
        end
        // Hand leftover slots round robin
        S_FILL: begin
          if (!fill_more) begin
            state <= S_RESP;
          end else begin
            if (cur_s < cur_q) begin
              slots[k] <= cur_s + 1'b1;
              used     <= used + 1'b1;
            end
            k <= (k == LastIdx) ? '0 : k + 1'b1;
          end
        end
        S_RESP: begin
          rsp.valid         <= 1'b1;
          rsp.start_allowed <= (s_new != '0);
          rsp.share_slots   <= s_wide[FieldWidth-1:0];
          rsp.share_queued  <= q_wide[FieldWidth-1:0];
          state             <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign q_wide = 32'(q_new);
  assign s_wide = 32'(s_new);

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready) else $error("ready while busy");
  a_simple_result: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.action != ACT_RECALC) |=> rsp.valid)
    else $error("missing result word");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && prio_sum != '0) |-> (rem < prio_sum))
    else $error("divider remainder out of range");
  a_resp_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |-> !rsp.valid) else $error("result register busy");
endmodule
`default_nettype wire
